FILE: sv/scc_pkg.sv
// scc_pkg: shared types and constants of the span coverage accumulator
// used by scc_cfg, span_coverage_accumulator and the bench; no dependencies
package scc_pkg;

  // default store geometry
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 128;

  // signed width of a computed cell address (holds base plus column)
  localparam int CELL_ADDR_W = 26;

  // coverage of one fully covered cell in subpixels
  localparam logic [7:0] FULL_CELL = 8'h08;

  // request kinds and store selection
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;
  localparam logic PLANE_BODY    = 1'b0;
  localparam logic PLANE_BORDER  = 1'b1;

  // register map, index = paddr / 4
  localparam int          CFG_ADDR_W    = 5;
  localparam logic [2:0]  REG_X_OFFSET  = 3'd0;
  localparam logic [2:0]  REG_Y_OFFSET  = 3'd1;
  localparam logic [2:0]  REG_CLIP_EN   = 3'd2;
  localparam logic [2:0]  REG_RIGHT_LIM = 3'd3;
  localparam logic [2:0]  REG_BOTTOM    = 3'd4;
  localparam logic [2:0]  REG_PITCH     = 3'd5;

  // register reset values
  localparam logic [8:0] RIGHT_LIMIT_RST  = 9'd256;
  localparam logic [7:0] BOTTOM_LIMIT_RST = 8'd128;
  localparam logic [8:0] ROW_PITCH_RST    = 9'd256;

  // configuration seen by the datapath
  typedef struct packed {
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic               clip_enable;
    logic        [8:0]  right_limit;
    logic        [7:0]  bottom_limit;
    logic        [8:0]  row_pitch;
  } cfg_t;

endpackage

FILE: sv/scc_ram.sv
// scc_ram: generic single write port, single read port RAM with registered read
// depends on nothing; instanced for each coverage store
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/scc_cfg.sv
// scc_cfg: configuration registers behind an APB-style slave port
// depends on scc_pkg for the register map and the cfg_t struct
module scc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output scc_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[scc_pkg::CFG_ADDR_W-1:2];

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset     <= '0;
      cfg.y_offset     <= '0;
      cfg.clip_enable  <= 1'b0;
      cfg.right_limit  <= scc_pkg::RIGHT_LIMIT_RST;
      cfg.bottom_limit <= scc_pkg::BOTTOM_LIMIT_RST;
      cfg.row_pitch    <= scc_pkg::ROW_PITCH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        scc_pkg::REG_X_OFFSET:  cfg.x_offset     <= pwdata[15:0];
        scc_pkg::REG_Y_OFFSET:  cfg.y_offset     <= pwdata[15:0];
        scc_pkg::REG_CLIP_EN:   cfg.clip_enable  <= pwdata[0];
        scc_pkg::REG_RIGHT_LIM: cfg.right_limit  <= pwdata[8:0];
        scc_pkg::REG_BOTTOM:    cfg.bottom_limit <= pwdata[7:0];
        scc_pkg::REG_PITCH:     cfg.row_pitch    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // readback, offsets sign extended
  always_comb begin
    unique case (reg_idx)
      scc_pkg::REG_X_OFFSET:  prdata = 32'(cfg.x_offset);
      scc_pkg::REG_Y_OFFSET:  prdata = 32'(cfg.y_offset);
      scc_pkg::REG_CLIP_EN:   prdata = {31'd0, cfg.clip_enable};
      scc_pkg::REG_RIGHT_LIM: prdata = {23'd0, cfg.right_limit};
      scc_pkg::REG_BOTTOM:    prdata = {24'd0, cfg.bottom_limit};
      scc_pkg::REG_PITCH:     prdata = {23'd0, cfg.row_pitch};
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: sv/span_coverage_accumulator.sv
// span_coverage_accumulator: top level, sequencer and cell datapath
// depends on scc_pkg, scc_cfg and scc_ram
//
// Accumulates 1/8-pixel span coverage into a body or border byte store of
// MAX_COLUMNS*MAX_ROWS cells each, or reads back one cell. After reset both
// stores are cleared by a pass over all MAX_COLUMNS*MAX_ROWS cells (32768 at
// the default size) during which s_tready stays low; register writes are
// taken throughout. One request is handled at a time. An accumulate request
// goes through setup, clipping and row-base multiply, then for each covered
// cell inside the store a read then a write through the single write port
// of the store, and for each covered cell outside it a step that only marks
// the span dropped, then loads the result register; an empty or dropped span
// skips the multiply and the cell loop. A read request goes through setup,
// address check and data read. s_tready is high only in S_IDLE. Each
// request yields exactly one result; s_tready returns high once the result
// is loaded, even if it has not yet been taken, and the next result waits
// in S_DONE until the previous one is taken.
module span_coverage_accumulator #(
  parameter int MAX_COLUMNS = scc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = scc_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // span_row[15:0], span_start[31:16], span_end[47:32],
  // read_column[55:48], read_row[62:56], zero[63]
  input  logic [63:0]                    s_tdata,
  // operation[0], plane[1]
  input  logic [1:0]                     s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // cell_value[7:0]
  output logic [7:0]                     m_tdata,
  // span_dropped[0]
  output logic                           m_tuser,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = scc_pkg::CELL_ADDR_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_CLIP, S_BASE,
    S_CELL_RD, S_CELL_WR, S_READ_ADDR, S_READ_DATA, S_DONE
  } state_t;

  state_t state;
  scc_pkg::cfg_t cfg;

  // request registers
  logic               op;
  logic               plane;
  logic signed [15:0] span_row;
  logic signed [15:0] span_start;
  logic signed [15:0] span_end;
  logic        [7:0]  read_column;
  logic        [6:0]  read_row;

  // working registers
  logic signed [16:0] y_sub;
  logic signed [16:0] x1;
  logic signed [16:0] x2;
  logic        [16:0] rd_addr;
  logic signed [13:0] first;
  logic signed [13:0] last;
  logic signed [13:0] row;
  logic signed [13:0] cur;
  logic signed [23:0] base;
  logic        [AW-1:0] cell_waddr;
  logic        [7:0]  amount;
  logic        [7:0]  value;
  logic               dropped;
  logic        [AW-1:0] clr_addr;

  // combinational datapath
  logic signed [16:0] x2_m1;
  logic signed [13:0] first_c;
  logic signed [13:0] last_c;
  logic signed [13:0] row_c;
  logic signed [13:0] first_k;
  logic signed [13:0] last_k;
  logic               clip_drop;
  logic signed [CW-1:0] cell_addr;
  logic               cell_in;
  logic               rd_in;
  logic        [7:0]  amount_c;
  logic        [7:0]  rdata_body;
  logic        [7:0]  rdata_border;
  logic        [7:0]  rdata_sel;
  logic               we_body;
  logic               we_border;
  logic        [AW-1:0] waddr;
  logic        [7:0]  wdata;
  logic        [AW-1:0] raddr;

  scc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s_tready = (state == S_IDLE);

  // cell indexes and clipping
  always_comb begin
    x2_m1     = x2 - 17'sd1;
    first_c   = 14'(x1 >>> 3);
    last_c    = 14'(x2_m1 >>> 3);
    row_c     = 14'(y_sub >>> 3);
    first_k   = first_c;
    last_k    = last_c;
    clip_drop = 1'b0;
    if (cfg.clip_enable) begin
      if (row_c < 14'sd0 || row_c >= $signed({6'd0, cfg.bottom_limit}) ||
          last_c < 14'sd0) begin
        clip_drop = 1'b1;
      end else begin
        if (first_c < 14'sd0) begin
          first_k = '0;
        end
        if (first_k > $signed({5'd0, cfg.right_limit})) begin
          clip_drop = 1'b1;
        end else if (last_c > $signed({5'd0, cfg.right_limit})) begin
          last_k = $signed({5'd0, cfg.right_limit});
        end
      end
    end
  end

  // shared address adder and range check
  assign cell_addr = CW'(base) + CW'(cur);
  assign cell_in   = !cell_addr[CW-1] && (cell_addr < DEPTH_C);
  assign rd_in     = (CW'(rd_addr) < DEPTH_C);

  // coverage for the current cell, modulo 256
  always_comb begin
    priority if (first == last) begin
      amount_c = x2[7:0] - x1[7:0];
    end else if (cur == first) begin
      amount_c = {first[4:0], 3'd0} + scc_pkg::FULL_CELL - x1[7:0];
    end else if (cur == last) begin
      amount_c = x2[7:0] - {last[4:0], 3'd0};
    end else begin
      amount_c = scc_pkg::FULL_CELL;
    end
  end

  // store ports
  assign rdata_sel = (plane == scc_pkg::PLANE_BORDER) ? rdata_border : rdata_body;

  always_comb begin
    if (state == S_CLEAR) begin
      we_body   = 1'b1;
      we_border = 1'b1;
      waddr     = clr_addr;
      wdata     = '0;
    end else begin
      we_body   = (state == S_CELL_WR) && (plane == scc_pkg::PLANE_BODY);
      we_border = (state == S_CELL_WR) && (plane == scc_pkg::PLANE_BORDER);
      waddr     = cell_waddr;
      wdata     = rdata_sel + amount;
    end
    if (state == S_READ_ADDR) begin
      raddr = AW'(rd_addr);
    end else begin
      raddr = cell_addr[AW-1:0];
    end
  end

  scc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_body (
    .clk   (clk),
    .we    (we_body),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_body)
  );

  scc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_border (
    .clk   (clk),
    .we    (we_border),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_border)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op          <= s_tuser[0];
            plane       <= s_tuser[1];
            span_row    <= s_tdata[15:0];
            span_start  <= s_tdata[31:16];
            span_end    <= s_tdata[47:32];
            read_column <= s_tdata[55:48];
            read_row    <= s_tdata[62:56];
            dropped     <= 1'b0;
            value       <= '0;
            state       <= S_SETUP;
          end
        end
        S_SETUP: begin
          y_sub   <= 17'(span_row) + 17'(cfg.y_offset);
          x1      <= 17'(span_start) + 17'(cfg.x_offset);
          x2      <= 17'(span_end) + 17'(cfg.x_offset);
          rd_addr <= 17'(cfg.row_pitch) * 17'(read_row) + 17'(read_column);
          if (op == scc_pkg::OP_READ) begin
            state <= S_READ_ADDR;
          end else begin
            state <= S_CLIP;
          end
        end
        S_CLIP: begin
          first <= first_k;
          last  <= last_k;
          row   <= row_c;
          if (x2 <= x1) begin
            state <= S_DONE;
          end else if (clip_drop) begin
            dropped <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          base  <= 24'($signed({1'b0, cfg.row_pitch})) * 24'(row);
          cur   <= first;
          state <= S_CELL_RD;
        end
        S_CELL_RD: begin
          cell_waddr <= cell_addr[AW-1:0];
          amount     <= amount_c;
          if (cell_in) begin
            state <= S_CELL_WR;
          end else begin
            dropped <= 1'b1;
            cur     <= cur + 14'sd1;
            state   <= (cur == last) ? S_DONE : S_CELL_RD;
          end
        end
        S_CELL_WR: begin
          cur   <= cur + 14'sd1;
          state <= (cur == last) ? S_DONE : S_CELL_RD;
        end
        S_READ_ADDR: begin
          if (rd_in) begin
            state <= S_READ_DATA;
          end else begin
            dropped <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_READ_DATA: begin
          value <= rdata_sel;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= value;
            m_tuser  <= dropped;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/span_coverage_accumulator_tb.sv
// span_coverage_accumulator_tb: self-checking bench for the span coverage accumulator
// drives span/read requests and register writes, predicts every result from its own
// copy of both coverage stores; depends on scc_pkg and span_coverage_accumulator
module span_coverage_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = scc_pkg::MAX_COLUMNS_DEF * scc_pkg::MAX_ROWS_DEF;
  // cell window that most random spans and reads aim at
  localparam int WIN_ROWS = 8;
  localparam int WIN_COLS = 32;

  typedef struct {
    logic               op;
    logic               plane;
    logic signed [15:0] row;
    logic signed [15:0] x_start;
    logic signed [15:0] x_end;
    logic        [7:0]  rd_col;
    logic        [6:0]  rd_row;
  } span_req_t;

  typedef struct {
    logic [7:0] cell_value;
    logic       dropped;
  } cov_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [scc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  span_coverage_accumulator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // mirrored configuration and coverage stores
  int x_off_m = 0;
  int y_off_m = 0;
  bit clip_m = 1'b0;
  int right_m = int'(scc_pkg::RIGHT_LIMIT_RST);
  int bottom_m = int'(scc_pkg::BOTTOM_LIMIT_RST);
  int pitch_m = int'(scc_pkg::ROW_PITCH_RST);
  bit [7:0] coverage [2][STORE_DEPTH];

  span_req_t   pending_reqs[$];
  cov_result_t cell_results_due[$];
  span_req_t   cur_req;
  bit          req_taken = 1'b0;
  bit          idle_on = 1'b1;
  int          gap_left = 0;
  int          stall_left = 0;
  int          mismatches = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // append one request to the driver queue
  function automatic void add_req(span_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // mostly short gaps, now and then a long one; none while idle_on is clear
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(17, 90);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    unique case (idx)
      scc_pkg::REG_X_OFFSET:  x_off_m = $signed(v[15:0]);
      scc_pkg::REG_Y_OFFSET:  y_off_m = $signed(v[15:0]);
      scc_pkg::REG_CLIP_EN:   clip_m = v[0];
      scc_pkg::REG_RIGHT_LIM: right_m = int'(v[8:0]);
      scc_pkg::REG_BOTTOM:    bottom_m = int'(v[7:0]);
      scc_pkg::REG_PITCH:     pitch_m = int'(v[8:0]);
      default: ;
    endcase
  endfunction

  // add coverage to one cell, false when the address falls outside the store
  function automatic bit add_cov(logic p, int addr, int amount);
    if (addr < 0 || addr >= STORE_DEPTH) return 1'b0;
    coverage[p][addr] = coverage[p][addr] + amount[7:0];
    return 1'b1;
  endfunction

  // expected result of one request, updating the mirrored store
  function automatic cov_result_t update_coverage(span_req_t r);
    cov_result_t res;
    int addr, y, x1, x2, first, last, crow, base, c;
    bit keep;
    res.cell_value = 8'd0;
    res.dropped = 1'b0;
    if (r.op == scc_pkg::OP_READ) begin
      addr = pitch_m * int'(r.rd_row) + int'(r.rd_col);
      if (addr < STORE_DEPTH) res.cell_value = coverage[r.plane][addr];
      else res.dropped = 1'b1;
    end else begin
      y  = int'(r.row) + y_off_m;
      x1 = int'(r.x_start) + x_off_m;
      x2 = int'(r.x_end) + x_off_m;
      if (x2 > x1) begin
        first = x1 >>> 3;
        last  = (x2 - 1) >>> 3;
        crow  = y >>> 3;
        keep  = 1'b1;
        // clipping against bottom, left edge and right limit
        if (clip_m) begin
          if (crow < 0 || crow >= bottom_m || last < 0) begin
            keep = 1'b0;
          end else begin
            if (first < 0) first = 0;
            if (first > right_m) keep = 1'b0;
            else if (last > right_m) last = right_m;
          end
        end
        if (!keep) begin
          res.dropped = 1'b1;
        end else begin
          base = pitch_m * crow;
          if (first == last) begin
            if (!add_cov(r.plane, base + first, x2 - x1)) res.dropped = 1'b1;
          end else begin
            // end cells keep partial coverage computed from the unclamped x
            if (!add_cov(r.plane, base + first, (first + 1) * 8 - x1)) res.dropped = 1'b1;
            for (c = first + 1; c < last; c++)
              if (!add_cov(r.plane, base + c, int'(scc_pkg::FULL_CELL))) res.dropped = 1'b1;
            if (!add_cov(r.plane, base + last, x2 - last * 8)) res.dropped = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // span given in post-offset subpixels, converted back to raw request fields
  function automatic span_req_t aimed_span(logic plane, int y, int x1, int x2);
    span_req_t r;
    r.op = scc_pkg::OP_ACCUMULATE;
    r.plane = plane;
    r.row = 16'(y - y_off_m);
    r.x_start = 16'(x1 - x_off_m);
    r.x_end = 16'(x2 - x_off_m);
    r.rd_col = '0;
    r.rd_row = '0;
    return r;
  endfunction

  function automatic span_req_t cell_read(logic plane, int col, int row);
    span_req_t r;
    r = aimed_span(plane, 0, 0, 0);
    r.op = scc_pkg::OP_READ;
    r.rd_col = 8'(col);
    r.rd_row = 7'(row);
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (s_tvalid && req_taken) nv = 1'b0;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          s_tdata <= {1'b0, cur_req.rd_row, cur_req.rd_col, cur_req.x_end,
                      cur_req.x_start, cur_req.row};
          s_tuser <= {cur_req.plane, cur_req.op};
          nv = 1'b1;
          gap_left = pick_gap();
        end
      end
    end
    req_taken = 1'b0;
    s_tvalid <= nv;
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // prediction on accepted requests, comparison on accepted results
  always @(posedge clk) begin
    cov_result_t due;
    if (!rst && s_tvalid && s_tready) begin
      cell_results_due.insert(cell_results_due.size(), update_coverage(cur_req));
      req_taken = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (cell_results_due.size() == 0) begin
        $error("result with no request outstanding: cell_value %0d span_dropped %0d",
               m_tdata, m_tuser);
        mismatches++;
      end else begin
        due = cell_results_due.pop_front();
        if (m_tdata !== due.cell_value) begin
          $error("cell_value: expected %0d, got %0d", due.cell_value, m_tdata);
          mismatches++;
        end
        if (m_tuser !== due.dropped) begin
          $error("span_dropped: expected %0d, got %0d", due.dropped, m_tuser);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(int xo, int yo, int clip, int right, int bottom, int pitch);
    write_reg(scc_pkg::REG_X_OFFSET, 32'(xo));
    write_reg(scc_pkg::REG_Y_OFFSET, 32'(yo));
    write_reg(scc_pkg::REG_CLIP_EN, 32'(clip));
    write_reg(scc_pkg::REG_RIGHT_LIM, 32'(right));
    write_reg(scc_pkg::REG_BOTTOM, 32'(bottom));
    write_reg(scc_pkg::REG_PITCH, 32'(pitch));
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || cell_results_due.size() != 0)
      @(posedge clk);
  endtask

  // random mix: window spans and read-backs, plus noise and clip-edge spans
  task automatic queue_random(int n);
    span_req_t r;
    int k, x0, len, cr, cc;
    logic [7:0] rc;
    logic [6:0] rr;
    repeat (n) begin
      k = $urandom_range(0, 99);
      r.op = scc_pkg::OP_ACCUMULATE;
      r.plane = 1'($urandom);
      r.row = 16'($urandom);
      r.x_start = 16'($urandom);
      r.x_end = 16'($urandom);
      rc = 8'($urandom);
      rr = 7'($urandom);
      if (k < 45) begin
        x0 = $urandom_range(0, WIN_COLS * 8 - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 48);
        r = aimed_span(r.plane, $urandom_range(0, WIN_ROWS * 8 - 1), x0, x0 + len);
      end else if (k < 75) begin
        r.op = scc_pkg::OP_READ;
        rc = 8'($urandom_range(0, WIN_COLS - 1));
        rr = 7'($urandom_range(0, WIN_ROWS - 1));
      end else if (k < 85) begin
        // random placement, rarely a full-length span
        if ($urandom_range(0, 29) != 0) r.x_end = r.x_start + 16'($urandom_range(0, 40));
      end else if (k < 93) begin
        r.op = scc_pkg::OP_READ;
      end else begin
        cr = int'($urandom_range(0, bottom_m + 3)) - 2;
        cc = int'($urandom_range(0, right_m + 4)) - 3;
        x0 = cc * 8 + int'($urandom_range(0, 7));
        len = $urandom_range(1, 64);
        r = aimed_span(r.plane, cr * 8 + int'($urandom_range(0, 7)), x0, x0 + len);
      end
      r.rd_col = rc;
      r.rd_row = rr;
      add_req(r);
    end
  endtask

  task automatic run_phase(int xo, int yo, int clip, int right, int bottom, int pitch,
                           int n, bit idle);
    set_config(xo, yo, clip, right, bottom, pitch);
    idle_on = idle;
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: partial, full and empty spans, store edges, extremes
    add_req(cell_read(scc_pkg::PLANE_BODY, 0, 0));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 0, 3, 6));
    add_req(cell_read(scc_pkg::PLANE_BODY, 0, 0));
    add_req(aimed_span(scc_pkg::PLANE_BORDER, 9, 5, 37));
    add_req(cell_read(scc_pkg::PLANE_BORDER, 1, 1));
    add_req(cell_read(scc_pkg::PLANE_BORDER, 4, 1));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 0, 40, 40));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 0, 50, 10));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 0, -20, 12));
    add_req(cell_read(scc_pkg::PLANE_BODY, 1, 0));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 1016, 2040, 2048));
    add_req(cell_read(scc_pkg::PLANE_BODY, 255, 127));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 1024, 0, 8));
    add_req(aimed_span(scc_pkg::PLANE_BORDER, 32767, -32768, 32767));
    add_req(aimed_span(scc_pkg::PLANE_BODY, -32768, -32768, -32760));
    add_req(cell_read(scc_pkg::PLANE_BORDER, 0, 127));
    queue_random(340);
    wait_drained();

    // clipping: bottom, left edge, right limit, clamped end cells wrapping
    set_config(13, -11, 1, 20, 5, 256);
    add_req(aimed_span(scc_pkg::PLANE_BODY, -1, 0, 8));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 40, 0, 8));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 8, -16, -8));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 8, -10, 10));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 8, 168, 180));
    add_req(aimed_span(scc_pkg::PLANE_BODY, 16, 160, 170));
    add_req(aimed_span(scc_pkg::PLANE_BORDER, 32, 0, 2000));
    add_req(cell_read(scc_pkg::PLANE_BORDER, 20, 4));
    add_req(cell_read(scc_pkg::PLANE_BODY, 0, 1));
    queue_random(250);
    wait_drained();

    run_phase(-32768, -32768, 1, 0, 0, 1, 60, 1'b1);
    run_phase(32767, 32767, 1, 256, 128, 1, 150, 1'b0);
    run_phase(-5, 3, 0, 256, 128, 0, 300, 1'b1);
    run_phase(100, -60, 1, 255, 127, 200, 300, 1'b1);
    run_phase(0, 0, 0, 7, 3, 256, 300, 1'b0);

    repeat (40) @(posedge clk);
    if (cell_results_due.size() != 0) begin
      $error("%0d expected results never arrived", cell_results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, covers the store clearing pass and the slowest spans
  initial begin
    #(100_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
